>>> rtl/saeu_pkg.sv
`timescale 1ns / 1ps
package saeu_pkg;

    typedef enum logic [2:0] {
        OP_ADDB = 3'd0,
        OP_ADDW = 3'd1,
        OP_ADDD = 3'd2,
        OP_SUBB = 3'd3,
        OP_SUBW = 3'd4,
        OP_SUBD = 3'd5,
        OP_MULD = 3'd6,
        OP_ADDSD = 3'd7
    } op_t;

    localparam logic [63:0] DEFAULT_NAN = 64'hFFF8000000000000;
    localparam logic [63:0] QUIET_BIT   = 64'h0008000000000000;

    // Input beat fields
    typedef struct packed {
        logic [63:0] src_high;
        logic [63:0] src_low;
        logic [63:0] dest_high;
        logic [63:0] dest_low;
        logic        wide;
        logic [2:0]  mode;
    } in_beat_t;

endpackage

>>> rtl/saeu_lanes.sv
`timescale 1ns / 1ps
module saeu_lanes (
    input  logic [2:0]  mode,
    input  logic [63:0] a,
    input  logic [63:0] b,
    output logic [63:0] y
);
    import saeu_pkg::*;

    logic [63:0] sum8, sum16, sum32;
    logic [63:0] dif8, dif16, dif32;
    logic [63:0] prod;

    // Per-lane wrap-around add/sub and 32-bit low multiply
    always_comb begin
        for (int i = 0; i < 8; i++) begin
            sum8[i*8 +: 8] = a[i*8 +: 8] + b[i*8 +: 8];
            dif8[i*8 +: 8] = a[i*8 +: 8] - b[i*8 +: 8];
        end
        for (int i = 0; i < 4; i++) begin
            sum16[i*16 +: 16] = a[i*16 +: 16] + b[i*16 +: 16];
            dif16[i*16 +: 16] = a[i*16 +: 16] - b[i*16 +: 16];
        end
        for (int i = 0; i < 2; i++) begin
            sum32[i*32 +: 32] = a[i*32 +: 32] + b[i*32 +: 32];
            dif32[i*32 +: 32] = a[i*32 +: 32] - b[i*32 +: 32];
            prod[i*32 +: 32]  = a[i*32 +: 32] * b[i*32 +: 32];
        end
    end

    always_comb begin
        case (op_t'(mode))
            OP_ADDB: y = sum8;
            OP_ADDW: y = sum16;
            OP_ADDD: y = sum32;
            OP_SUBB: y = dif8;
            OP_SUBW: y = dif16;
            OP_SUBD: y = dif32;
            OP_MULD: y = prod;
            default: y = a;
        endcase
    end
endmodule

>>> rtl/saeu_dadd.sv
`timescale 1ns / 1ps
module saeu_dadd (
    input  logic [63:0] a,
    input  logic [63:0] b,
    output logic [63:0] y
);
    import saeu_pkg::*;

    logic        sa, sb, sl, ss;
    logic [10:0] ea, eb, el, es;
    logic [51:0] fa, fb;
    logic [61:0] ma, mb, ml, ms, msh;
    logic        a_nan, b_nan, swap, stk;
    logic [11:0] d;
    logic [62:0] r;
    logic [5:0]  lz;
    logic [12:0] e;
    logic [61:0] rn;
    logic [8:0]  rem;
    logic [53:0] q;
    logic        found;

    always_comb begin
        sa = a[63]; sb = b[63];
        ea = a[62:52]; eb = b[62:52];
        fa = a[51:0]; fb = b[51:0];
        a_nan = (ea == 11'h7FF) && (fa != 52'd0);
        b_nan = (eb == 11'h7FF) && (fb != 52'd0);
        ma = {(ea != 11'd0), fa, 9'd0};
        mb = {(eb != 11'd0), fb, 9'd0};
        if (ea == 11'd0) ea = 11'd1;
        if (eb == 11'd0) eb = 11'd1;
        swap = (eb > ea) || ((eb == ea) && (mb > ma));
        sl = swap ? sb : sa; ss = swap ? sa : sb;
        el = swap ? eb : ea; es = swap ? ea : eb;
        ml = swap ? mb : ma; ms = swap ? ma : mb;
        d = {1'b0, el - es};
        stk = 1'b0;
        // Align smaller operand with sticky
        if (d >= 12'd63) begin
            msh = {61'd0, (ms != 62'd0)};
        end else begin
            msh = ms >> d[5:0];
            stk = (ms & ((62'd1 << d[5:0]) - 62'd1)) != 62'd0;
            msh[0] = msh[0] | stk;
        end
        r = (sl == ss) ? ({1'b0, ml} + {1'b0, msh}) : ({1'b0, ml} - {1'b0, msh});
        e = {2'b0, el};
        if (r[62]) begin
            rn = r[62:1];
            rn[0] = rn[0] | r[0];
            e = e + 13'd1;
        end else begin
            rn = r[61:0];
        end
        // Normalize, stopping at exponent 1
        lz = 6'd0; found = 1'b0;
        for (int i = 61; i >= 0; i--) begin
            if (!found && rn[i]) begin
                found = 1'b1;
                lz = 6'(61 - i);
            end
        end
        if (!found) lz = 6'd61;
        if (e > 13'd1) begin
            if ({7'd0, lz} > e - 13'd1) lz = 6'(e - 13'd1);
        end else begin
            lz = 6'd0;
        end
        rn = rn << lz;
        e = e - {7'd0, lz};
        rem = rn[8:0];
        q = {1'b0, rn[61:9]};
        if (rem > 9'd256 || (rem == 9'd256 && q[0])) q = q + 54'd1;
        if (q[53]) begin
            q = q >> 1;
            e = e + 13'd1;
        end
        // Special cases
        if (a_nan) y = a | QUIET_BIT;
        else if (b_nan) y = b | QUIET_BIT;
        else if (a[62:52] == 11'h7FF)
            y = (b[62:52] == 11'h7FF && sa != sb) ? DEFAULT_NAN : a;
        else if (b[62:52] == 11'h7FF) y = b;
        else if (r == 63'd0) y = (sl == ss) ? {sl, 63'd0} : 64'd0;
        else if (e >= 13'h7FF) y = {sl, 11'h7FF, 52'd0};
        else y = {sl, (q[52] ? e[10:0] : 11'd0), q[51:0]};
    end
endmodule

>>> rtl/simd_arith_execute_unit.sv
`timescale 1ns / 1ps
// SIMD execute unit: packed add/sub on 8/16/32-bit lanes, 32-bit low multiply,
// and scalar double add with round-to-nearest-even. One beat is taken per
// cycle unless the input side stalls; a result passes through the input
// register and then the result register before it is offered. The input
// side stalls only while both registers are full and the result is not taken.
module simd_arith_execute_unit (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [263:0] s_tdata,  // mode[2:0], wide, dest_low, dest_high, src_low, src_high
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [127:0] m_tdata   // result_low, result_high
);
    import saeu_pkg::*;

    in_beat_t    in_reg;
    logic        in_vld_reg, out_vld_reg;
    logic [127:0] out_reg;
    logic [63:0] lane_lo, lane_hi, dbl;
    logic [63:0] res_lo, res_hi;
    logic        adv_out;

    assign adv_out  = !out_vld_reg || m_tready;
    assign s_tready = !in_vld_reg || adv_out;

    // Capture input beat
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (s_tready) begin
            in_vld_reg <= s_tvalid;
        end
        if (s_tready && s_tvalid) in_reg <= in_beat_t'(s_tdata[259:0]);
    end

    saeu_lanes u_lo (.mode(in_reg.mode), .a(in_reg.dest_low),  .b(in_reg.src_low),  .y(lane_lo));
    saeu_lanes u_hi (.mode(in_reg.mode), .a(in_reg.dest_high), .b(in_reg.src_high), .y(lane_hi));
    saeu_dadd  u_dadd (.a(in_reg.dest_low), .b(in_reg.src_low), .y(dbl));

    // Select result halves
    always_comb begin
        res_lo = (op_t'(in_reg.mode) == OP_ADDSD) ? dbl : lane_lo;
        if (op_t'(in_reg.mode) == OP_MULD) res_hi = lane_hi;
        else if (op_t'(in_reg.mode) == OP_ADDSD || !in_reg.wide) res_hi = in_reg.dest_high;
        else res_hi = lane_hi;
    end

    // Hold result until taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (adv_out) begin
            out_vld_reg <= in_vld_reg;
        end
        if (adv_out && in_vld_reg) out_reg <= {res_hi, res_lo};
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = out_reg;

`ifndef NO_ASSERTIONS
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)) else $error("result dropped");
    a_flow: assert property (@(posedge aclk) disable iff (!aresetn)
        in_vld_reg && adv_out |=> m_tvalid) else $error("beat lost");
    a_rdy: assert property (@(posedge aclk) disable iff (!aresetn)
        !in_vld_reg |-> s_tready) else $error("stall while empty");
`endif
endmodule
